// ===== rtl/core/aob_pkg.sv =====
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants for the alpha-over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_OFFSET_X      = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y      = 3'd1;
  localparam logic [2:0] CFG_DEST_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_LAYER_OPACITY = 3'd4;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Clip limit on the destination size
  localparam int MAX_DIM = 4096;

  // Quotient bits of every blend division, one per divider stage
  localparam int DIV_STEPS = 8;
  // Width of the doubled, rounded channel numerator
  localparam int REM_W = 27;
  // Width of the doubled blend denominator
  localparam int DEN_W = 18;
  // Lanes through the divider: red, green, blue
  localparam int LANES = 3;

  typedef struct packed {
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
    logic [7:0]  dst_red;
    logic [7:0]  dst_green;
    logic [7:0]  dst_blue;
    logic [7:0]  dst_alpha;
  } pix_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] target_x;
    logic [11:0] target_y;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
  } res_t;

endpackage

// ===== rtl/core/alpha_over_blend_with_opacity.sv =====
// ----------------------------------------------------------------------------
// alpha_over_blend_with_opacity
// A pixel transfer passes through the placement, divide, weight and numerator stages and the divider to res_data.
// Throughput: one pixel per cycle; the whole pipeline holds while res_stall
// is high with a result waiting, and pix_stall follows that hold.
// The divider takes one quotient bit per stage over eight stages.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// registers: offsets 0, size 4096 by 4096, opacity 255.
// ----------------------------------------------------------------------------
module alpha_over_blend_with_opacity
  import aob_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pix_t                 pix_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NDS = DIV_STEPS;

  // Configuration registers
  logic signed [12:0] offset_x;
  logic signed [12:0] offset_y;
  logic [12:0]        dest_width;
  logic [12:0]        dest_height;
  logic [7:0]         layer_opacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      dest_width    <= 13'd4096;
      dest_height   <= 13'd4096;
      layer_opacity <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_X:      offset_x      <= cfg_data;
        CFG_OFFSET_Y:      offset_y      <= cfg_data;
        CFG_DEST_WIDTH:    dest_width    <= cfg_data;
        CFG_DEST_HEIGHT:   dest_height   <= cfg_data;
        CFG_LAYER_OPACITY: layer_opacity <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together unless a result is held at the output
  logic en;
  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;

  localparam logic [15:0] MAX_DIM16 = 16'(MAX_DIM);

  logic [15:0] eff_w;
  logic [15:0] eff_h;
  assign eff_w = ({3'b0, dest_width} < MAX_DIM16) ? {3'b0, dest_width} : MAX_DIM16;
  assign eff_h = ({3'b0, dest_height} < MAX_DIM16) ? {3'b0, dest_height} : MAX_DIM16;

  // ---------------- stage 1: placement, clip, alpha times opacity
  logic signed [13:0] tx_c;
  logic signed [13:0] ty_c;
  logic               in_c;
  assign tx_c = $signed({2'b0, pix_data.src_x}) + $signed({offset_x[12], offset_x});
  assign ty_c = $signed({2'b0, pix_data.src_y}) + $signed({offset_y[12], offset_y});
  assign in_c = !tx_c[13] && ({2'b0, tx_c} < eff_w) &&
                !ty_c[13] && ({2'b0, ty_c} < eff_h);

  logic        v1;
  logic        in1;
  logic [11:0] tx1;
  logic [11:0] ty1;
  logic [15:0] ax1;
  pix_t        p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1 <= in_c;
      tx1 <= tx_c[11:0];
      ty1 <= ty_c[11:0];
      ax1 <= 16'(pix_data.src_alpha * layer_opacity) + 16'd127;
      p1  <= pix_data;
    end
  end

  // ---------------- stage 2: divide by 255 (reciprocal 257/65536, one fixup)
  logic [23:0] rcp;
  logic [7:0]  q0;
  logic [15:0] r0;
  logic [7:0]  sa_c;
  assign rcp  = {8'b0, ax1} + {ax1, 8'b0};
  assign q0   = rcp[23:16];
  assign r0   = ax1 - (({q0, 8'b0}) - {8'b0, q0});
  assign sa_c = (r0 >= 16'd255) ? q0 + 8'd1 : q0;

  logic        v2;
  logic        we2;
  logic [11:0] tx2;
  logic [11:0] ty2;
  logic [7:0]  sa2;
  pix_t        p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      we2 <= in1 && (sa_c != 8'd0);
      tx2 <= tx1;
      ty2 <= ty1;
      sa2 <= sa_c;
      p2  <= p1;
    end
  end

  // ---------------- stage 3: weights and source products
  logic [7:0] inv_c;
  assign inv_c = 8'd255 - sa2;

  logic        v3;
  logic        we3;
  logic [11:0] tx3;
  logic [11:0] ty3;
  logic [15:0] w3;      // Da*(255-Sa)
  logic [15:0] sw3;     // Sa*255
  logic [15:0] ps3 [0:2];
  logic [7:0]  dc3 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      we3    <= we2;
      tx3    <= tx2;
      ty3    <= ty2;
      w3     <= p2.dst_alpha * inv_c;
      sw3    <= {sa2, 8'b0} - {8'b0, sa2};
      ps3[0] <= p2.src_red * sa2;
      ps3[1] <= p2.src_green * sa2;
      ps3[2] <= p2.src_blue * sa2;
      dc3[0] <= p2.dst_red;
      dc3[1] <= p2.dst_green;
      dc3[2] <= p2.dst_blue;
    end
  end

  // ---------------- stage 4: numerators and denominator
  logic [16:0]      den_c;
  logic [REM_W-1:0] num_c [0:LANES-1];

  always_comb begin
    den_c = {1'b0, sw3} + {1'b0, w3};
    for (int c = 0; c < LANES; c++) begin
      num_c[c] = ((REM_W'({ps3[c], 8'b0}) - REM_W'(ps3[c]) + REM_W'(dc3[c] * w3)) << 1)
                 + REM_W'(den_c);
    end
  end

  // Divider stages: index 0 is the stage-4 register, index NDS the output
  logic             dv  [0:NDS];
  logic             dwe [0:NDS];
  logic [11:0]      dtx [0:NDS];
  logic [11:0]      dty [0:NDS];
  logic [DEN_W-1:0] dden[0:NDS];
  logic [REM_W-1:0] rem [0:NDS][0:LANES-1];
  logic [7:0]       quo [0:NDS][0:LANES-1];
  logic [15:0]      dad0;   // D + 127

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dwe[0]  <= we3;
      dtx[0]  <= tx3;
      dty[0]  <= ty3;
      dden[0] <= {den_c, 1'b0};
      dad0    <= den_c[15:0] + 16'd127;
      for (int c = 0; c < LANES; c++) begin
        rem[0][c] <= num_c[c];
        quo[0][c] <= '0;
      end
    end
  end

  // out_alpha = (2*D + 255) / 510 = (D + 127) / 255, same reciprocal as stage 2
  logic [23:0] arcp;
  logic [7:0]  aq0;
  logic [15:0] ar0;
  logic [7:0]  al_c;
  logic [7:0]  dal [1:NDS];
  assign arcp = {8'b0, dad0} + {dad0, 8'b0};
  assign aq0  = arcp[23:16];
  assign ar0  = dad0 - (({aq0, 8'b0}) - {8'b0, aq0});
  assign al_c = (ar0 >= 16'd255) ? aq0 + 8'd1 : aq0;

  for (genvar j = 1; j <= NDS; j++) begin : g_div
    localparam int SH = NDS - j;
    logic [REM_W-1:0] dsh  [0:LANES-1];
    logic             take [0:LANES-1];

    always_comb begin
      for (int c = 0; c < LANES; c++) begin
        dsh[c]  = REM_W'(dden[j-1]) << SH;
        take[c] = rem[j-1][c] >= dsh[c];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dwe[j]  <= dwe[j-1];
        dtx[j]  <= dtx[j-1];
        dty[j]  <= dty[j-1];
        dden[j] <= dden[j-1];
        for (int c = 0; c < LANES; c++) begin
          rem[j][c] <= take[c] ? rem[j-1][c] - dsh[c] : rem[j-1][c];
          quo[j][c] <= quo[j-1][c] | (take[c] ? 8'(1 << SH) : 8'd0);
        end
      end
    end

    if (j == 1) begin : g_al_first
      always_ff @(posedge clk) begin
        if (en) begin
          dal[j] <= al_c;
        end
      end
    end else begin : g_al_next
      always_ff @(posedge clk) begin
        if (en) begin
          dal[j] <= dal[j-1];
        end
      end
    end
  end

  // Output: fields read zero when no write is flagged
  logic wr;
  assign wr        = dwe[NDS];
  assign res_valid = dv[NDS];

  always_comb begin
    res_data.write_enable = wr;
    res_data.target_x     = wr ? dtx[NDS] : 12'd0;
    res_data.target_y     = wr ? dty[NDS] : 12'd0;
    res_data.out_red      = wr ? quo[NDS][0] : 8'd0;
    res_data.out_green    = wr ? quo[NDS][1] : 8'd0;
    res_data.out_blue     = wr ? quo[NDS][2] : 8'd0;
    res_data.out_alpha    = wr ? dal[NDS] : 8'd0;
  end

endmodule

// ===== rtl/core/aob_checker.sv =====
// ----------------------------------------------------------------------------
// aob_checker
// Port-level checks on the alpha-over blend pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module aob_checker
  import aob_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 pix_valid,
  input logic                 pix_stall,
  input pix_t                 pix_data,
  input logic                 res_valid,
  input logic                 res_stall,
  input res_t                 res_data,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // input side holds exactly when a result is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    pix_stall == (res_valid && res_stall))
    else $error("pix_stall does not follow output hold");

  // no-write results carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.write_enable |->
      res_data.target_x == 12'd0 && res_data.target_y == 12'd0 &&
      res_data.out_red == 8'd0 && res_data.out_green == 8'd0 &&
      res_data.out_blue == 8'd0 && res_data.out_alpha == 8'd0)
    else $error("nonzero fields on a no-write result");

  // a written pixel always has coverage
  a_alpha_nz: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.write_enable |-> res_data.out_alpha != 8'd0)
    else $error("written pixel with zero alpha");

endmodule

bind alpha_over_blend_with_opacity aob_checker u_aob_checker (.*);

// ===== tb/tb_alpha_over_blend_with_opacity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_over_blend_with_opacity
// Self-checking bench for the alpha-over blend pipeline. Directed rows cover
// clipping edges, opacity extremes and blend corners; random pixels follow
// under several register settings, with random idle on both channels.
// ----------------------------------------------------------------------------
module tb_alpha_over_blend_with_opacity;
  import aob_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pix_t                 pix_data = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  alpha_over_blend_with_opacity u_dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers
  int          sh_off_x, sh_off_y, sh_width, sh_height, sh_opacity;
  res_t        blend_q[$];
  int          errors = 0;
  int          n_pix = 0, n_res = 0, n_writes = 0, n_clipped = 0;
  logic        stim_done = 1'b0;

  function automatic res_t blend_pixel(pix_t p);
    res_t r;
    int tx, ty, wlim, hlim;
    longint sa, da, d, nr, ng, nb;
    r = '0;
    tx = int'(p.src_x) + sh_off_x;
    ty = int'(p.src_y) + sh_off_y;
    wlim = (sh_width < MAX_DIM) ? sh_width : MAX_DIM;
    hlim = (sh_height < MAX_DIM) ? sh_height : MAX_DIM;
    sa = (longint'(p.src_alpha) * sh_opacity + 127) / 255;
    if (tx < 0 || tx >= wlim || ty < 0 || ty >= hlim || sa == 0) return r;
    da = p.dst_alpha;
    d = sa * 255 + da * (255 - sa);
    nr = p.src_red * sa * 255 + p.dst_red * da * (255 - sa);
    ng = p.src_green * sa * 255 + p.dst_green * da * (255 - sa);
    nb = p.src_blue * sa * 255 + p.dst_blue * da * (255 - sa);
    r.write_enable = 1'b1;
    r.target_x  = tx[11:0];
    r.target_y  = ty[11:0];
    r.out_red   = 8'((2 * nr + d) / (2 * d));
    r.out_green = 8'((2 * ng + d) / (2 * d));
    r.out_blue  = 8'((2 * nb + d) / (2 * d));
    r.out_alpha = 8'((2 * d + 255) / 510);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET_X:      sh_off_x   = int'(signed'(val[CFG_W-1:0]));
      CFG_OFFSET_Y:      sh_off_y   = int'(signed'(val[CFG_W-1:0]));
      CFG_DEST_WIDTH:    sh_width   = val & 13'h1FFF;
      CFG_DEST_HEIGHT:   sh_height  = val & 13'h1FFF;
      CFG_LAYER_OPACITY: sh_opacity = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_all(input int ox, oy, w, h, op);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_DEST_WIDTH, w);
    write_reg(CFG_DEST_HEIGHT, h);
    write_reg(CFG_LAYER_OPACITY, op);
  endtask

  // wait until every expected result has come back, with the inputs idle
  task automatic drain();
    pix_valid <= 1'b0;
    while (blend_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // one pixel transfer; valid stays high across back-to-back transfers
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    blend_q.push_back(blend_pixel(p));
    n_pix++;
    @(negedge clk);
  endtask

  function automatic pix_t rand_pixel(input int wlim, input int hlim);
    pix_t p;
    p = pix_t'({$urandom, $urandom, $urandom});
    // keep most pixels inside the window so the blend path dominates
    if ($urandom_range(0, 9) != 0) begin
      p.src_x = 12'($urandom_range(0, wlim - 1) - sh_off_x);
      p.src_y = 12'($urandom_range(0, hlim - 1) - sh_off_y);
    end
    case ($urandom_range(0, 7))
      0: p.src_alpha = 8'hFF;
      1: p.dst_alpha = 8'h00;
      2: p.src_alpha = 8'($urandom_range(0, 2));
      default: ;
    endcase
    return p;
  endfunction

  // directed rows; with exp_on set, a typed-in result is checked against the predictor
  typedef struct {
    pix_t p;
    bit   exp_on;
    res_t e;
  } row_t;

  task automatic run_row(input row_t row);
    if (row.exp_on && row.e !== blend_pixel(row.p)) begin
      $error("directed row table entry disagrees with predictor");
      errors++;
    end
    send_pixel(row.p);
  endtask

  // result side: before each result is taken, stall is at random held high
  initial begin
    int w;
    @(negedge clk iff !rst);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (w != 0) begin
        res_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      n_res++;
      if (blend_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = blend_q.pop_front();
        if (e.write_enable) n_writes++; else n_clipped++;
        if (res_data.write_enable !== e.write_enable) begin
          $error("write_enable exp %0d got %0d", e.write_enable, res_data.write_enable);
          errors++;
        end
        if (res_data.target_x !== e.target_x) begin
          $error("target_x exp %0d got %0d", e.target_x, res_data.target_x);
          errors++;
        end
        if (res_data.target_y !== e.target_y) begin
          $error("target_y exp %0d got %0d", e.target_y, res_data.target_y);
          errors++;
        end
        if (res_data.out_red !== e.out_red) begin
          $error("out_red exp %0d got %0d", e.out_red, res_data.out_red);
          errors++;
        end
        if (res_data.out_green !== e.out_green) begin
          $error("out_green exp %0d got %0d", e.out_green, res_data.out_green);
          errors++;
        end
        if (res_data.out_blue !== e.out_blue) begin
          $error("out_blue exp %0d got %0d", e.out_blue, res_data.out_blue);
          errors++;
        end
        if (res_data.out_alpha !== e.out_alpha) begin
          $error("out_alpha exp %0d got %0d", e.out_alpha, res_data.out_alpha);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    pix_t p;
    res_t z;
    int   wl, hl;
    sh_off_x = 0; sh_off_y = 0; sh_width = 4096; sh_height = 4096; sh_opacity = 255;
    z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: opaque source copies straight through
    rows.push_back('{pix_t'({12'd0, 12'd0, 8'd10, 8'd20, 8'd30, 8'hFF,
                             8'd1, 8'd2, 8'd3, 8'd4}), 1,
                     res_t'({1'b1, 12'd0, 12'd0, 8'd10, 8'd20, 8'd30, 8'hFF})});
    rows.push_back('{pix_t'({12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                             8'h00, 8'h00, 8'h00, 8'h00}), 1,
                     res_t'({1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF})});
    // transparent source: no write
    rows.push_back('{pix_t'({12'd5, 12'd6, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                             8'hFF, 8'hFF, 8'hFF, 8'hFF}), 1, z});
    // partial alpha blends, both destination alpha extremes
    rows.push_back('{pix_t'({12'd7, 12'd8, 8'hFF, 8'h00, 8'h80, 8'h80,
                             8'h00, 8'hFF, 8'h40, 8'hFF}), 0, z});
    rows.push_back('{pix_t'({12'd7, 12'd8, 8'hFF, 8'h00, 8'h80, 8'h01,
                             8'h00, 8'hFF, 8'h40, 8'h00}), 0, z});
    rows.push_back('{pix_t'({12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hAA, 8'h55,
                             8'h55, 8'hAA, 8'h55, 8'hAA}), 0, z});
    foreach (rows[i]) run_row(rows[i]);
    drain();

    // low opacity: alpha 1 rounds to zero, alpha 255 survives
    set_all(-5, 4095, 100, 4096, 1);
    rows.delete();
    rows.push_back('{pix_t'({12'd10, 12'd0, 8'd9, 8'd9, 8'd9, 8'h01,
                             8'd0, 8'd0, 8'd0, 8'd0}), 1, z});
    rows.push_back('{pix_t'({12'd10, 12'd0, 8'd9, 8'd9, 8'd9, 8'hFF,
                             8'd0, 8'd0, 8'd0, 8'd0}), 0, z});
    // clip edges: x = -1, x = width, y = size
    rows.push_back('{pix_t'({12'd4, 12'd0, 8'd9, 8'd9, 8'd9, 8'hFF,
                             8'd0, 8'd0, 8'd0, 8'hFF}), 1, z});
    rows.push_back('{pix_t'({12'd105, 12'd0, 8'd9, 8'd9, 8'd9, 8'hFF,
                             8'd0, 8'd0, 8'd0, 8'hFF}), 1, z});
    rows.push_back('{pix_t'({12'd104, 12'd0, 8'd9, 8'd9, 8'd9, 8'hFF,
                             8'd7, 8'd7, 8'd7, 8'hFF}), 0, z});
    rows.push_back('{pix_t'({12'd5, 12'd1, 8'd9, 8'd9, 8'd9, 8'hFF,
                             8'd7, 8'd7, 8'd7, 8'hFF}), 1, z});
    foreach (rows[i]) run_row(rows[i]);
    drain();

    // opacity 0 and size 0 clip everything; oversize width clamps
    set_all(4095, -4096, 8191, 0, 0);
    rows.delete();
    rows.push_back('{pix_t'({12'd0, 12'hFFF, 8'd1, 8'd1, 8'd1, 8'hFF,
                             8'd1, 8'd1, 8'd1, 8'hFF}), 1, z});
    foreach (rows[i]) run_row(rows[i]);
    drain();
    write_reg(CFG_LAYER_OPACITY, 255);
    write_reg(CFG_DEST_HEIGHT, 1);
    write_reg(CFG_OFFSET_Y, 0);
    write_reg(CFG_OFFSET_X, -4096);
    rows.delete();
    rows.push_back('{pix_t'({12'hFFF, 12'd0, 8'd3, 8'd3, 8'd3, 8'hFF,
                             8'd1, 8'd1, 8'd1, 8'hFF}), 0, z});
    foreach (rows[i]) run_row(rows[i]);
    drain();

    // random phases under varied settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all(0, 0, 4096, 4096, 255);
        1: set_all(0, 0, 4096, 4096, $urandom_range(0, 255));
        2: set_all(-4096, 4095, 4096, 4096, 128);
        7: set_all(0, 0, 1, 1, 255);
        default: set_all($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                         $urandom_range(1, 4096), $urandom_range(1, 4096),
                         $urandom_range(0, 255));
      endcase
      wl = (sh_width < MAX_DIM) ? sh_width : MAX_DIM;
      hl = (sh_height < MAX_DIM) ? sh_height : MAX_DIM;
      for (int k = 0; k < 140; k++) begin
        p = rand_pixel(wl, hl);
        send_pixel(p);
        // hold off once until everything in flight has come back
        if (ph == 3 && k == 70) begin
          pix_valid <= 1'b0;
          while (blend_q.size() != 0) @(negedge clk);
        end
      end
      pix_valid <= 1'b0;
      drain();
    end
    stim_done = 1'b1;

    $display("Sent %0d pixels over 12 register settings; %0d results checked,",
             n_pix, n_res);
    $display("%0d blended writes and %0d clipped or transparent.", n_writes, n_clipped);
    if (errors == 0 && blend_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
